[sv/tsc_pkg.sv]
`default_nettype none
package tsc_pkg;

	localparam int CITY_W = 6;
	localparam int OP_W = 2;
	localparam int POS_W = CITY_W + 1;
	localparam int CFG_IDX_W = 1;
	localparam int MAX_TOUR_ENTRIES_DEF = 64;

	localparam logic [OP_W-1:0] OP_LOAD_FIRST = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_SECOND = 2'd1;
	localparam logic [OP_W-1:0] OP_RUN = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_CITIES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_CITY = 1'b1;

	localparam logic [CITY_W-1:0] RST_NUM_CITIES = 6'd48;
	localparam logic [CITY_W-1:0] RST_START_CITY = 6'd1;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_COPY = 5'b00010,
		ST_FILL_POS = 5'b00100,
		ST_FILL_CHK = 5'b01000,
		ST_OUT = 5'b10000
	} tsc_state_t;

endpackage
`default_nettype wire

[sv/tour_segment_crossover_core.sv]
`default_nettype none
// Flow. A load item is written into its parent store as it is accepted. A run is accepted in
// idle, writes the start city at position 0, copies the clipped parent-one segment, fills the
// other positions from parent two, fetches the first city, then outputs T entries (T = tour entries).
// One item in flight: no new item is accepted until the last output of a run is taken.
// Reset (arst_n low, asynchronous): sequencer idle, load counts and used-city map cleared,
// num_cities = 48, start_city = 1. The three tour stores are not cleared.
module tour_segment_crossover_core #(
	parameter int MAX_TOUR_ENTRIES = tsc_pkg::MAX_TOUR_ENTRIES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	// configuration write channel
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [tsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [tsc_pkg::CITY_W-1:0] cfg_data,
	// input stream
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [23:0] s_tdata, // [5:0] city, [11:6] segment_offset, [17:12] segment_length
	input wire logic [1:0] s_tuser, // [1:0] op
	// output stream
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [7:0] m_tdata, // [5:0] child_city
	output logic m_tlast
);

	localparam int AW = $clog2(MAX_TOUR_ENTRIES);
	localparam int CW = tsc_pkg::CITY_W;
	localparam int PW = tsc_pkg::POS_W;
	localparam logic [PW-1:0] MAX_POS = PW'(MAX_TOUR_ENTRIES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TOUR_ENTRIES - 1);

	// input field split
	logic [CW-1:0] in_city;
	logic [CW-1:0] in_offset;
	logic [CW-1:0] in_length;
	logic [tsc_pkg::OP_W-1:0] in_op;

	assign in_city = s_tdata[5:0];
	assign in_offset = s_tdata[11:6];
	assign in_length = s_tdata[17:12];
	assign in_op = s_tuser;

	// configuration
	logic [CW-1:0] num_cities_q;
	logic [CW-1:0] start_city_q;

	// sequencer state
	tsc_pkg::tsc_state_t state_q, state_d;
	logic [AW-1:0] first_cnt_q, second_cnt_q;
	logic [63:0] used_q;
	logic [PW-1:0] tour_len_q; // T, tour entries of this run
	logic [PW-1:0] seg_start_q; // first copied position, clipped to 1
	logic [PW-1:0] seg_end_q; // one past the last copied position
	logic [PW-1:0] copy_pos_q; // parent-one read position
	logic pend_s1; // parent-one read data arrives this cycle
	logic [PW-1:0] pend_pos_s1;
	logic [PW-1:0] fill_pos_q; // child position being filled
	logic [PW-1:0] scan_pos_q; // parent-two scan pointer
	logic [PW-1:0] out_pos_q;

	// RAM ports
	logic first_we, first_re, second_we, second_re, child_we, child_re;
	logic [AW-1:0] first_waddr, first_raddr, second_waddr, second_raddr;
	logic [AW-1:0] child_waddr, child_raddr;
	logic [CW-1:0] first_rdata, second_rdata, child_wdata, child_rdata;

	// run setup: tour length and clipped segment bounds
	logic [PW-1:0] run_tour_len, run_tour_last, run_seg_start, run_seg_sum, run_seg_end;

	always_comb begin
		run_tour_len = {1'b0, num_cities_q} + PW'(1);
		if (run_tour_len > MAX_POS) begin
			run_tour_len = MAX_POS;
		end
		run_tour_last = run_tour_len - PW'(1);
		run_seg_start = (in_offset == '0) ? PW'(1) : {1'b0, in_offset};
		run_seg_sum = run_seg_start + {1'b0, in_length};
		run_seg_end = (run_seg_sum > run_tour_last) ? run_tour_last : run_seg_sum;
	end

	logic in_accept, out_accept, out_last;
	logic copy_issue, fill_in_seg, scan_hit;

	assign s_tready = (state_q == tsc_pkg::ST_IDLE);
	assign in_accept = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign m_tvalid = (state_q == tsc_pkg::ST_OUT);
	assign out_last = (out_pos_q == tour_len_q - PW'(1));
	assign m_tlast = out_last;
	assign m_tdata = {2'b00, child_rdata};
	assign out_accept = m_tvalid && m_tready;

	assign copy_issue = (copy_pos_q < seg_end_q);
	assign fill_in_seg = (fill_pos_q >= seg_start_q) && (fill_pos_q < seg_end_q);
	assign scan_hit = !used_q[second_rdata];

	// next state and memory controls
	always_comb begin
		state_d = state_q;
		first_we = 1'b0;
		first_waddr = first_cnt_q;
		first_re = 1'b0;
		first_raddr = copy_pos_q[AW-1:0];
		second_we = 1'b0;
		second_waddr = second_cnt_q;
		second_re = 1'b0;
		second_raddr = scan_pos_q[AW-1:0];
		child_we = 1'b0;
		child_waddr = fill_pos_q[AW-1:0];
		child_wdata = '0;
		child_re = 1'b0;
		child_raddr = '0;
		unique case (state_q)
			tsc_pkg::ST_IDLE: begin
				if (in_accept) begin
					case (in_op)
						tsc_pkg::OP_LOAD_FIRST: begin
							first_we = 1'b1;
						end
						tsc_pkg::OP_LOAD_SECOND: begin
							second_we = 1'b1;
						end
						tsc_pkg::OP_RUN: begin
							// position 0 always holds the start city
							child_we = 1'b1;
							child_waddr = '0;
							child_wdata = start_city_q;
							state_d = tsc_pkg::ST_COPY;
						end
						default: begin
						end
					endcase
				end
			end
			tsc_pkg::ST_COPY: begin
				first_re = copy_issue;
				if (pend_s1) begin
					child_we = 1'b1;
					child_waddr = pend_pos_s1[AW-1:0];
					child_wdata = first_rdata;
				end
				if (!copy_issue && !pend_s1) begin
					state_d = tsc_pkg::ST_FILL_POS;
				end
			end
			tsc_pkg::ST_FILL_POS: begin
				if (fill_pos_q >= tour_len_q) begin
					child_re = 1'b1;
					state_d = tsc_pkg::ST_OUT;
				end else if (!fill_in_seg) begin
					if (scan_pos_q >= tour_len_q) begin
						// parent two exhausted
						child_we = 1'b1;
					end else begin
						second_re = 1'b1;
						state_d = tsc_pkg::ST_FILL_CHK;
					end
				end
			end
			tsc_pkg::ST_FILL_CHK: begin
				if (scan_hit) begin
					child_we = 1'b1;
					child_wdata = second_rdata;
				end
				state_d = tsc_pkg::ST_FILL_POS;
			end
			tsc_pkg::ST_OUT: begin
				if (out_accept) begin
					if (out_last) begin
						state_d = tsc_pkg::ST_IDLE;
					end else begin
						child_re = 1'b1;
						child_raddr = out_pos_q[AW-1:0] + AW'(1);
					end
				end
			end
			default: begin
				state_d = tsc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsc_pkg::ST_IDLE;
			num_cities_q <= tsc_pkg::RST_NUM_CITIES;
			start_city_q <= tsc_pkg::RST_START_CITY;
			first_cnt_q <= '0;
			second_cnt_q <= '0;
			used_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					tsc_pkg::CFG_NUM_CITIES: num_cities_q <= cfg_data;
					tsc_pkg::CFG_START_CITY: start_city_q <= cfg_data;
					default: begin
					end
				endcase
			end
			// advance load counters, wrapping at the store depth
			if (first_we) begin
				first_cnt_q <= (first_cnt_q == LAST_ADDR) ? '0 : first_cnt_q + AW'(1);
			end
			if (second_we) begin
				second_cnt_q <= (second_cnt_q == LAST_ADDR) ? '0 : second_cnt_q + AW'(1);
			end
			if (out_accept && out_last) begin
				first_cnt_q <= '0;
				second_cnt_q <= '0;
			end
			pend_s1 <= (state_q == tsc_pkg::ST_COPY) && copy_issue;
			// used-city map: clear on run start, mark copied and picked cities
			if (in_accept && in_op == tsc_pkg::OP_RUN) begin
				used_q <= '0;
			end else if (state_q == tsc_pkg::ST_COPY && pend_s1) begin
				used_q[first_rdata] <= 1'b1;
			end else if (state_q == tsc_pkg::ST_FILL_CHK && scan_hit) begin
				used_q[second_rdata] <= 1'b1;
			end
		end
	end

	// position registers, all written before use on each run
	always_ff @(posedge clk) begin
		pend_pos_s1 <= copy_pos_q;
		if (in_accept && in_op == tsc_pkg::OP_RUN) begin
			tour_len_q <= run_tour_len;
			seg_start_q <= run_seg_start;
			seg_end_q <= run_seg_end;
			copy_pos_q <= run_seg_start;
			fill_pos_q <= PW'(1);
			scan_pos_q <= PW'(1);
		end
		if (state_q == tsc_pkg::ST_COPY && copy_issue) begin
			copy_pos_q <= copy_pos_q + PW'(1);
		end
		if (state_q == tsc_pkg::ST_FILL_POS && fill_pos_q < tour_len_q) begin
			if (fill_in_seg || scan_pos_q >= tour_len_q) begin
				fill_pos_q <= fill_pos_q + PW'(1);
			end
		end
		if (state_q == tsc_pkg::ST_FILL_CHK) begin
			// on a hit hold the scan pointer; that entry now reads as used
			if (scan_hit) begin
				fill_pos_q <= fill_pos_q + PW'(1);
			end else begin
				scan_pos_q <= scan_pos_q + PW'(1);
			end
		end
		if (state_q == tsc_pkg::ST_FILL_POS && fill_pos_q >= tour_len_q) begin
			out_pos_q <= '0;
		end else if (out_accept && !out_last) begin
			out_pos_q <= out_pos_q + PW'(1);
		end
	end

	tsc_ram #(.WIDTH(CW), .DEPTH(MAX_TOUR_ENTRIES)) u_first_ram (
		.clk(clk),
		.we(first_we),
		.waddr(first_waddr),
		.wdata(in_city),
		.re(first_re),
		.raddr(first_raddr),
		.rdata(first_rdata)
	);

	tsc_ram #(.WIDTH(CW), .DEPTH(MAX_TOUR_ENTRIES)) u_second_ram (
		.clk(clk),
		.we(second_we),
		.waddr(second_waddr),
		.wdata(in_city),
		.re(second_re),
		.raddr(second_raddr),
		.rdata(second_rdata)
	);

	tsc_ram #(.WIDTH(CW), .DEPTH(MAX_TOUR_ENTRIES)) u_child_ram (
		.clk(clk),
		.we(child_we),
		.waddr(child_waddr),
		.wdata(child_wdata),
		.re(child_re),
		.raddr(child_raddr),
		.rdata(child_rdata)
	);

	// one item in flight: never accept while a result is offered
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input accepted while output pending");

	// the final output returns the block to idle with load counts cleared
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_accept && m_tlast |=> s_tready && first_cnt_q == '0 && second_cnt_q == '0)
		else $error("run did not end cleanly");

	// the scan check only runs on a parent-two entry inside the tour
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tsc_pkg::ST_FILL_CHK |-> scan_pos_q < tour_len_q)
		else $error("parent-two scan past tour end");

	// a copied position lies inside the clipped segment, never position 0
	a_copy_range: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> pend_pos_s1 < seg_end_q && pend_pos_s1 != '0)
		else $error("segment copy out of range");

	// the fill position never runs past the tour length
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tsc_pkg::ST_FILL_CHK |-> fill_pos_q < tour_len_q)
		else $error("fill position out of range");

endmodule
`default_nettype wire

[sv/tsc_ram.sv]
`default_nettype none
module tsc_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 64
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold read data until the next read
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire
